// ===== rtl/tlb_page_table_cache_model_top_defines.svh =====
// Assertion macros shared by the checker of the translation and cache block.
`ifndef TLB_PAGE_TABLE_CACHE_MODEL_TOP_DEFINES_SVH
`define TLB_PAGE_TABLE_CACHE_MODEL_TOP_DEFINES_SVH

// immediate-cycle implication, clocked on clk_i, off during reset
`define TPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tpc assertion failed");

// next-cycle implication
`define TPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpc assertion failed");

`endif

// ===== rtl/tpc_pkg.sv =====
// Types and constants of the translation and cache block.
`default_nettype none
package tpc_pkg;

  localparam int unsigned VaW      = 10;
  localparam int unsigned StampW   = 32;
  localparam int unsigned OffW     = 4;
  localparam int unsigned PageW    = 6;
  localparam int unsigned FrameW   = 3;
  localparam int unsigned MemPages = 8;
  localparam int unsigned TlbCount = 16;
  localparam int unsigned TlbIdxW  = 4;
  localparam int unsigned SetW     = 2;
  localparam int unsigned Ways     = 4;
  localparam int unsigned WayW     = 2;
  localparam int unsigned Lines    = 16;

  typedef enum logic [1:0] {
    OUT_TLB_HIT = 2'd0,
    OUT_PT_HIT  = 2'd1,
    OUT_FAULT   = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [VaW-1:0]    virtual_address;
    logic [StampW-1:0] time_stamp;
  } req_t;

  typedef struct packed {
    logic [1:0]        translation_outcome;
    logic [FrameW-1:0] frame_number;
    logic              cache_hit;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic look;
    logic scan_frame;
    logic scan_tlb;
    logic fill;
    logic cache_upd;
  } cmd_t;

  typedef struct packed {
    logic tlb_hit;
    logic page_hit;
    logic last_frame;
    logic last_tlb;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/tlb_page_table_cache_model_top.sv =====
// Top level of the address translation and data cache block.
//
// One request beat (virtual byte address, time stamp) is taken at a clock
// edge with start high and busy low. busy then stays high until the result
// beat has been shown. The result (outcome, frame, cache hit) is shown on rsp_o
// while done_o is high for exactly one cycle; the receiver cannot stall it.
// States from the accepting edge to the result:
//   TLB hit:                   look-up, cache update, result
//   TLB miss, page table hit: look-up, TLB stamp scan, fill, cache update, result
//   page fault:               look-up, frame scan, TLB scan, fill, cache, result
// The scans walk the stored stamps one entry per cycle for the
// least-recently-stamped choice; the cache set is updated in the cache state.
// Reset clears the TLB, frame table and cache tags at once; the block
// accepts a request as soon as reset is released.
`default_nettype none
module tlb_page_table_cache_model_top (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start,
  output logic          busy,
  input  tpc_pkg::req_t req_i,
  output logic          done_o,
  output tpc_pkg::rsp_t rsp_o
);
  import tpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  tpc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  tpc_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

endmodule
`default_nettype wire

// ===== rtl/tpc_ctrl.sv =====
// Sequencer of the translation and cache block.
`default_nettype none
module tpc_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  tpc_pkg::status_t status_i,
  output tpc_pkg::cmd_t   cmd_o,
  output logic            busy_o,
  output logic            done_o
);
  import tpc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOOK  = 7'b0000010,
    ST_SCANF = 7'b0000100,
    ST_SCANT = 7'b0001000,
    ST_FILL  = 7'b0010000,
    ST_CACHE = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        if (status_i.tlb_hit) state_d = ST_CACHE;
        else if (status_i.page_hit) state_d = ST_SCANT;
        else state_d = ST_SCANF;
      end
      ST_SCANF: begin
        cmd_o.scan_frame = 1'b1;
        if (status_i.last_frame) state_d = ST_SCANT;
      end
      ST_SCANT: begin
        cmd_o.scan_tlb = 1'b1;
        if (status_i.last_tlb) state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = ST_CACHE;
      end
      ST_CACHE: begin
        cmd_o.cache_upd = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule
`default_nettype wire

// ===== rtl/tpc_datapath.sv =====
// TLB, frame table, cache tags and scan logic of the translation block.
`default_nettype none
module tpc_datapath (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  tpc_pkg::req_t    req_i,
  input  tpc_pkg::cmd_t    cmd_i,
  output tpc_pkg::status_t status_o,
  output tpc_pkg::rsp_t    rsp_o
);
  import tpc_pkg::*;

  logic [VaW-1:0]    va_q;
  logic [StampW-1:0] now_q;

  logic [PageW-1:0]  tlb_page_q  [TlbCount];
  logic [FrameW-1:0] tlb_frame_q [TlbCount];
  logic [StampW-1:0] tlb_stamp_q [TlbCount];
  logic [TlbCount-1:0] tlb_valid_q;

  logic [PageW-1:0]  owner_q       [MemPages];
  logic [StampW-1:0] frame_stamp_q [MemPages];
  logic [MemPages-1:0] frame_used_q;

  logic [FrameW-1:0] line_tag_q [Lines];
  logic [Lines-1:0]  line_valid_q;
  logic [Lines-1:0]  line_recent_q;

  logic [TlbIdxW-1:0] idx_q;
  outcome_e           outcome_q;
  logic [FrameW-1:0]  frame_q;
  rsp_t               rsp_q;

  logic               ffree_q, fhave_q;
  logic [FrameW-1:0]  ffree_idx_q, fbest_idx_q;
  logic [StampW-1:0]  fbest_q;
  logic               tfree_q, thave_q;
  logic [TlbIdxW-1:0] tfree_idx_q, tbest_idx_q;
  logic [StampW-1:0]  tbest_q;

  logic [PageW-1:0]   vpn;
  logic [SetW-1:0]    set_w;
  logic               tlb_hit, page_hit;
  logic [TlbIdxW-1:0] tlb_hit_idx;
  logic [FrameW-1:0]  page_hit_frame;
  logic [FrameW-1:0]  victim;
  logic               evict;
  logic               tlb_ent_valid;
  logic [TlbIdxW-1:0] tlb_pick;
  logic [FrameW-1:0]  fill_frame;
  logic [FrameW-1:0]  fidx;
  logic               c_hit, c_free;
  logic [WayW-1:0]    c_hit_way, c_free_way, c_old_way, c_way;
  logic [Ways-1:0]    rec_set, rec_new;

  assign vpn   = va_q[VaW-1:OffW];
  assign set_w = va_q[OffW-1:OffW-SetW];
  assign fidx  = idx_q[FrameW-1:0];

  always_comb begin
    tlb_hit     = 1'b0;
    tlb_hit_idx = '0;
    for (int k = TlbCount - 1; k >= 0; k--) begin
      if (tlb_valid_q[k] && tlb_page_q[k] == vpn) begin
        tlb_hit     = 1'b1;
        tlb_hit_idx = TlbIdxW'(k);
      end
    end
    page_hit       = 1'b0;
    page_hit_frame = '0;
    for (int f = 0; f < MemPages; f++) begin
      if (frame_used_q[f] && owner_q[f] == vpn) begin
        page_hit       = 1'b1;
        page_hit_frame = FrameW'(f);
      end
    end
  end

  assign victim        = ffree_q ? ffree_idx_q : fbest_idx_q;
  assign evict         = (outcome_q == OUT_FAULT) && !ffree_q;
  assign tlb_ent_valid = tlb_valid_q[idx_q] && !(evict && tlb_frame_q[idx_q] == victim);
  assign tlb_pick      = tfree_q ? tfree_idx_q : tbest_idx_q;
  assign fill_frame    = (outcome_q == OUT_FAULT) ? victim : frame_q;

  always_comb begin
    c_hit      = 1'b0;
    c_hit_way  = '0;
    c_free     = 1'b0;
    c_free_way = '0;
    c_old_way  = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      rec_set[w] = line_recent_q[{set_w, WayW'(w)}];
      if (line_valid_q[{set_w, WayW'(w)}] && line_tag_q[{set_w, WayW'(w)}] == frame_q) begin
        c_hit     = 1'b1;
        c_hit_way = WayW'(w);
      end
      if (!line_valid_q[{set_w, WayW'(w)}]) begin
        c_free     = 1'b1;
        c_free_way = WayW'(w);
      end
      if (!line_recent_q[{set_w, WayW'(w)}]) c_old_way = WayW'(w);
    end
    c_way   = c_hit ? c_hit_way : (c_free ? c_free_way : c_old_way);
    rec_new = rec_set | (Ways'(1) << c_way);
    if (&rec_new) rec_new = Ways'(1) << c_way;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q          <= '0;
      now_q         <= '0;
      tlb_valid_q   <= '0;
      frame_used_q  <= '0;
      line_valid_q  <= '0;
      line_recent_q <= '0;
      idx_q         <= '0;
      outcome_q     <= OUT_TLB_HIT;
      frame_q       <= '0;
      rsp_q         <= '0;
      ffree_q       <= 1'b0;
      fhave_q       <= 1'b0;
      ffree_idx_q   <= '0;
      fbest_idx_q   <= '0;
      fbest_q       <= '0;
      tfree_q       <= 1'b0;
      thave_q       <= 1'b0;
      tfree_idx_q   <= '0;
      tbest_idx_q   <= '0;
      tbest_q       <= '0;
      for (int k = 0; k < TlbCount; k++) begin
        tlb_page_q[k]  <= '0;
        tlb_frame_q[k] <= '0;
        tlb_stamp_q[k] <= '0;
      end
      for (int f = 0; f < MemPages; f++) begin
        owner_q[f]       <= '0;
        frame_stamp_q[f] <= '0;
      end
      for (int l = 0; l < Lines; l++) line_tag_q[l] <= '0;
    end else begin
      if (cmd_i.load) begin
        va_q  <= req_i.virtual_address;
        now_q <= req_i.time_stamp;
      end
      if (cmd_i.look) begin
        idx_q   <= '0;
        ffree_q <= 1'b0;
        fhave_q <= 1'b0;
        tfree_q <= 1'b0;
        thave_q <= 1'b0;
        if (tlb_hit) begin
          tlb_stamp_q[tlb_hit_idx] <= now_q;
          frame_q   <= tlb_frame_q[tlb_hit_idx];
          outcome_q <= OUT_TLB_HIT;
        end else if (page_hit) begin
          frame_q   <= page_hit_frame;
          outcome_q <= OUT_PT_HIT;
        end else begin
          outcome_q <= OUT_FAULT;
        end
      end
      if (cmd_i.scan_frame) begin
        if (!frame_used_q[fidx] && !ffree_q) begin
          ffree_q     <= 1'b1;
          ffree_idx_q <= fidx;
        end
        if (!fhave_q || frame_stamp_q[fidx] < fbest_q) begin
          fhave_q     <= 1'b1;
          fbest_q     <= frame_stamp_q[fidx];
          fbest_idx_q <= fidx;
        end
        idx_q <= status_o.last_frame ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.scan_tlb) begin
        if (!tlb_ent_valid) begin
          if (!tfree_q) begin
            tfree_q     <= 1'b1;
            tfree_idx_q <= idx_q;
          end
        end else if (!thave_q || tlb_stamp_q[idx_q] < tbest_q) begin
          thave_q     <= 1'b1;
          tbest_q     <= tlb_stamp_q[idx_q];
          tbest_idx_q <= idx_q;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fill) begin
        frame_stamp_q[fill_frame] <= now_q;
        if (outcome_q == OUT_FAULT) begin
          frame_q              <= victim;
          frame_used_q[victim] <= 1'b1;
          owner_q[victim]      <= vpn;
          if (evict) begin
            for (int k = 0; k < TlbCount; k++)
              if (tlb_frame_q[k] == victim && TlbIdxW'(k) != tlb_pick)
                tlb_valid_q[k] <= 1'b0;
            for (int l = 0; l < Lines; l++) begin
              if (line_valid_q[l] && line_tag_q[l] == victim) begin
                line_valid_q[l]  <= 1'b0;
                line_recent_q[l] <= 1'b0;
              end
            end
          end
        end
        tlb_valid_q[tlb_pick] <= 1'b1;
        tlb_stamp_q[tlb_pick] <= now_q;
        tlb_page_q[tlb_pick]  <= vpn;
        tlb_frame_q[tlb_pick] <= fill_frame;
      end
      if (cmd_i.cache_upd) begin
        for (int w = 0; w < Ways; w++) line_recent_q[{set_w, WayW'(w)}] <= rec_new[w];
        if (!c_hit) begin
          line_valid_q[{set_w, c_way}] <= 1'b1;
          line_tag_q[{set_w, c_way}]   <= frame_q;
        end
        rsp_q.translation_outcome <= outcome_q;
        rsp_q.frame_number        <= frame_q;
        rsp_q.cache_hit           <= c_hit;
      end
    end
  end

  assign status_o.tlb_hit    = tlb_hit;
  assign status_o.page_hit   = page_hit;
  assign status_o.last_frame = (fidx == FrameW'(MemPages - 1));
  assign status_o.last_tlb   = (idx_q == TlbIdxW'(TlbCount - 1));
  assign rsp_o               = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/tpc_checker.sv =====
// Port-level checker of the translation block and its bind.
`default_nettype none
`include "tlb_page_table_cache_model_top_defines.svh"
module tpc_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start,
  input wire           busy,
  input tpc_pkg::req_t req_i,
  input wire           done_o,
  input tpc_pkg::rsp_t rsp_o
);
  logic unused_payload;
  assign unused_payload = ^{req_i, rsp_o};

  `TPC_ASSERT(a_done_while_busy, !done_o || busy)
  `TPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TPC_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `TPC_ASSERT_NEXT(a_busy_until_done, busy && !done_o, busy)

endmodule

bind tlb_page_table_cache_model_top tpc_checker u_tpc_checker (.*);
`default_nettype wire

// ===== tb/sv/tlb_page_table_cache_model_top_tb.sv =====
// Testbench for the address translation and data cache block: scoreboard against a local predictor.
`default_nettype none
module tlb_page_table_cache_model_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpc_pkg::*;

  localparam int unsigned PageCount = 64;
  localparam int unsigned PageBytes = 16;
  localparam int unsigned BlockBytes = 4;
  localparam int unsigned Sets = 4;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  tlb_page_table_cache_model_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req_i), .done_o(done_o), .rsp_o(rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [PageW-1:0]  tp_page  [TlbCount];
  logic [FrameW-1:0] tp_frame [TlbCount];
  logic              tp_valid [TlbCount];
  logic [31:0]       tp_stamp [TlbCount];
  logic [FrameW-1:0] pt_frame [PageCount];
  logic              pt_valid [PageCount];
  logic              fr_used  [MemPages];
  logic [31:0]       fr_stamp [MemPages];
  logic [31:0]       ln_tag   [Lines];
  logic              ln_valid [Lines];
  logic              ln_recent[Lines];

  rsp_t expected_rsp_q[$];
  int   mismatch_count = 0;
  int   beats_sent = 0;
  int   beats_checked = 0;
  int   fault_count = 0;
  int   pt_hit_count = 0;
  int   tlb_hit_count = 0;
  longint unsigned cycle_count = 0;

  task automatic tlb_load(input int vpn, input logic [31:0] now);
    int pick;
    logic [31:0] best;
    bit have;
    pick = 0;
    best = 0;
    have = 0;
    for (int k = 0; k < TlbCount; k++) begin
      if (!tp_valid[k]) begin
        pick = k;
        break;
      end
      if (!have || tp_stamp[k] < best) begin
        best = tp_stamp[k];
        pick = k;
        have = 1;
      end
    end
    tp_valid[pick] = 1'b1;
    tp_stamp[pick] = now;
    tp_page[pick] = vpn[PageW-1:0];
    tp_frame[pick] = pt_frame[vpn];
  endtask

  task automatic mark_recent(input int set, input int way);
    bit all;
    all = 1;
    ln_recent[set*Ways+way] = 1'b1;
    for (int w = 0; w < Ways; w++) if (!ln_recent[set*Ways+w]) all = 0;
    if (all) for (int w = 0; w < Ways; w++) ln_recent[set*Ways+w] = 1'b0;
    ln_recent[set*Ways+way] = 1'b1;
  endtask

  task automatic take_frame(input int vpn, input logic [31:0] now, output int frame);
    int victim;
    logic [31:0] best;
    bit have;
    int blk;
    victim = 0;
    best = 0;
    have = 0;
    for (int f = 0; f < MemPages; f++) begin
      if (!fr_used[f]) begin
        fr_used[f] = 1'b1;
        fr_stamp[f] = now;
        pt_frame[vpn] = f;
        pt_valid[vpn] = 1'b1;
        tlb_load(vpn, now);
        frame = f;
        return;
      end
      if (!have || fr_stamp[f] < best) begin
        best = fr_stamp[f];
        victim = f;
        have = 1;
      end
    end
    fr_stamp[victim] = now;
    fr_used[victim] = 1'b1;
    for (int k = 0; k < TlbCount; k++) if (tp_frame[k] == victim) tp_valid[k] = 1'b0;
    for (int k = 0; k < PageCount; k++) if (pt_frame[k] == victim) pt_valid[k] = 1'b0;
    for (int k = 0; k < PageBytes; k++) begin
      blk = (victim * PageBytes + k) / BlockBytes;
      for (int w = 0; w < Ways; w++) begin
        if (ln_valid[(blk % Sets)*Ways+w] && ln_tag[(blk % Sets)*Ways+w] == blk / Sets) begin
          ln_valid[(blk % Sets)*Ways+w] = 1'b0;
          ln_recent[(blk % Sets)*Ways+w] = 1'b0;
        end
      end
    end
    pt_frame[vpn] = victim;
    pt_valid[vpn] = 1'b1;
    tlb_load(vpn, now);
    frame = victim;
  endtask

  task automatic predict_access(input req_t rq, output rsp_t rs);
    int vpn, off, frame, set, tag, pick, blk;
    outcome_e outcome;
    bit found, hit;
    vpn = (rq.virtual_address / PageBytes) % PageCount;
    off = rq.virtual_address % PageBytes;
    frame = 0;
    found = 0;
    hit = 0;
    outcome = OUT_FAULT;
    for (int k = 0; k < TlbCount; k++) begin
      if (tp_valid[k] && tp_page[k] == vpn) begin
        tp_stamp[k] = rq.time_stamp;
        frame = tp_frame[k];
        outcome = OUT_TLB_HIT;
        found = 1;
        break;
      end
    end
    if (!found) begin
      if (pt_valid[vpn]) begin
        tlb_load(vpn, rq.time_stamp);
        frame = pt_frame[vpn];
        fr_stamp[frame] = rq.time_stamp;
        outcome = OUT_PT_HIT;
      end else begin
        take_frame(vpn, rq.time_stamp, frame);
      end
    end
    blk = (frame * PageBytes + off) / BlockBytes;
    set = blk % Sets;
    tag = blk / Sets;
    for (int k = 0; k < Ways; k++) begin
      if (ln_valid[set*Ways+k] && ln_tag[set*Ways+k] == tag) begin
        mark_recent(set, k);
        hit = 1;
        break;
      end
    end
    if (!hit) begin
      pick = Ways;
      for (int k = 0; k < Ways; k++) if (pick == Ways && !ln_valid[set*Ways+k]) pick = k;
      for (int k = 0; k < Ways; k++) if (pick == Ways && !ln_recent[set*Ways+k]) pick = k;
      if (pick == Ways) pick = 0;
      mark_recent(set, pick);
      ln_valid[set*Ways+pick] = 1'b1;
      ln_tag[set*Ways+pick] = tag;
    end
    case (outcome)
      OUT_TLB_HIT: tlb_hit_count++;
      OUT_PT_HIT:  pt_hit_count++;
      default:     fault_count++;
    endcase
    rs.translation_outcome = outcome;
    rs.frame_number = frame[FrameW-1:0];
    rs.cache_hit = hit;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_checked, what, got, want);
    mismatch_count++;
  endtask

  // one beat; random gap before it in burst mode
  // start stays high between back-to-back beats and drops only at a gap or a drain
  int burst_left = 0;
  bit gaps_on = 1;

  task automatic send_access(input logic [VaW-1:0] va, input logic [31:0] ts);
    req_t rq;
    rsp_t rs;
    int gap;
    rq.virtual_address = va;
    rq.time_stamp = ts;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        if (start && gap > 0) start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_access(rq, rs);
    expected_rsp_q.push_back(rs);
    beats_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsp_q.size() == 0) begin
        $display("MISMATCH unexpected result beat");
        mismatch_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp_o.translation_outcome !== want.translation_outcome)
          report_mismatch("outcome", rsp_o.translation_outcome, want.translation_outcome);
        if (rsp_o.frame_number !== want.frame_number)
          report_mismatch("frame", rsp_o.frame_number, want.frame_number);
        if (rsp_o.cache_hit !== want.cache_hit)
          report_mismatch("cache_hit", rsp_o.cache_hit, want.cache_hit);
        beats_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_access(10'd0, 32'd0);
    send_access(10'd0, 32'd1);
    send_access(10'd1023, 32'hFFFF_FFFF);
    send_access(10'd1023, 32'h7FFF_FFFF);
    send_access(10'h2AA, 32'h5555_5555);
    send_access(10'h155, 32'hAAAA_AAAA);
    // fill all frames, then force victims
    for (int p = 0; p < 10; p++) send_access(10'((p + 8) * PageBytes + p), 32'(100 + p));
    send_access(10'd0, 32'd5);
    send_access(10'd4, 32'd6);
    send_access(10'd1020, 32'd0);
  endtask

  task automatic test_stalls_off();
    gaps_on = 0;
    for (int i = 0; i < 150; i++)
      send_access(10'($urandom_range(0, 255)), $urandom);
    gaps_on = 1;
  endtask

  task automatic test_random_mix();
    logic [31:0] ts;
    ts = $urandom;
    for (int i = 0; i < 1700; i++) begin
      ts += $urandom_range(0, 40);
      case ($urandom_range(0, 3))
        0: send_access(10'($urandom), $urandom);
        1: send_access(10'($urandom_range(0, 15) * PageBytes + $urandom_range(0, 15)), ts);
        default: send_access(10'($urandom_range(0, 159)), ts);
      endcase
      if (i == 800) drain_results();
    end
  endtask

  initial begin
    for (int k = 0; k < TlbCount; k++) begin
      tp_page[k] = '0; tp_frame[k] = '0; tp_valid[k] = 0; tp_stamp[k] = '0;
    end
    for (int k = 0; k < PageCount; k++) begin
      pt_frame[k] = '0; pt_valid[k] = 0;
    end
    for (int k = 0; k < MemPages; k++) begin
      fr_used[k] = 0; fr_stamp[k] = '0;
    end
    for (int k = 0; k < Lines; k++) begin
      ln_tag[k] = '0; ln_valid[k] = 0; ln_recent[k] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stalls_off();
    test_random_mix();
    drain_results();
    repeat (40) @(posedge clk_i);
    $display("%0d accesses checked: %0d TLB hits, %0d page-table hits, %0d page faults",
             beats_checked, tlb_hit_count, pt_hit_count, fault_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
